// ===== hdl/hexapod_gait_leg_trajectory_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the hexapod gait leg trajectory block
// Clocked, reset-qualified assertion wrappers used by the trajectory RTL file.
// -----------------------------------------------------------------------------
`ifndef HEXAPOD_GAIT_LEG_TRAJECTORY_ASSERT_SVH
`define HEXAPOD_GAIT_LEG_TRAJECTORY_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define HGL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define HGL_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

// ===== hdl/hgl_pkg.sv =====
// -----------------------------------------------------------------------------
// Hexapod gait package
// Shared widths, leg role codes and gait table lookups.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hgl_pkg;

   localparam int STEPS_DEFAULT = 8;
   localparam int NUM_LEGS      = 6;
   localparam int LEG_W         = 3;
   localparam int VEL_W         = 20;
   localparam int OFF_W         = 32;
   localparam int MUL_A_W       = 37;
   localparam int MUL_B_W       = 17;
   localparam int PROD_W        = 48;
   localparam int LIFT_Q16      = 1311;
   localparam int LIFT_W        = 11;

   localparam logic [1:0] GAIT_TRIPOD = 2'd0;
   localparam logic [1:0] GAIT_RIPPLE = 2'd1;
   localparam logic [1:0] GAIT_WAVE   = 2'd2;

   typedef enum logic [1:0] {
      ROLE_RET  = 2'd0,
      ROLE_UP   = 2'd1,
      ROLE_DOWN = 2'd2
   } role_type;

   // Number of phases of a gait minus two; selector three runs as tripod.
   function automatic logic [3:0] gait_c(input logic [1:0] gait);
      case (gait)
         GAIT_RIPPLE: gait_c = 4'd4;
         GAIT_WAVE:   gait_c = 4'd10;
         default:     gait_c = 4'd2;
      endcase
   endfunction

   function automatic logic [3:0] gait_last_phase(input logic [1:0] gait);
      case (gait)
         GAIT_RIPPLE: gait_last_phase = 4'd5;
         GAIT_WAVE:   gait_last_phase = 4'd11;
         default:     gait_last_phase = 4'd3;
      endcase
   endfunction

   function automatic role_type leg_role(input logic [1:0] gait, input logic [3:0] ph,
                                         input logic [LEG_W-1:0] leg);
      role_type r;
      r = ROLE_RET;
      case (gait)
         GAIT_RIPPLE: begin
            case (ph)
               4'd0: r = (leg == 3'd1) ? ROLE_DOWN : (leg == 3'd5) ? ROLE_UP : ROLE_RET;
               4'd1: r = (leg == 3'd0) ? ROLE_UP : (leg == 3'd5) ? ROLE_DOWN : ROLE_RET;
               4'd2: r = (leg == 3'd0) ? ROLE_DOWN : (leg == 3'd4) ? ROLE_UP : ROLE_RET;
               4'd3: r = (leg == 3'd2) ? ROLE_UP : (leg == 3'd4) ? ROLE_DOWN : ROLE_RET;
               4'd4: r = (leg == 3'd2) ? ROLE_DOWN : (leg == 3'd3) ? ROLE_UP : ROLE_RET;
               4'd5: r = (leg == 3'd1) ? ROLE_UP : (leg == 3'd3) ? ROLE_DOWN : ROLE_RET;
               default: r = ROLE_RET;
            endcase
         end
         GAIT_WAVE: begin
            if (leg == ph[3:1]) begin
               r = ph[0] ? ROLE_DOWN : ROLE_UP;
            end
         end
         default: begin
            if (leg[0] == ph[1]) begin
               r = ph[0] ? ROLE_DOWN : ROLE_UP;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [OFF_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(2147483647);
      lo = -hi - PROD_W'(1);
      if (v > hi) begin
         return OFF_W'(hi);
      end else if (v < lo) begin
         return OFF_W'(lo);
      end
      return v[OFF_W-1:0];
   endfunction

endpackage

// ===== hdl/hgl_mul.sv =====
// -----------------------------------------------------------------------------
// Hexapod gait shared multiplier
// Signed multiply with a registered, truncated product.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hgl_mul
   import hgl_pkg::*;
(
   input  logic                       clock,
   input  logic signed [MUL_A_W-1:0]  mul_a,
   input  logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]   prod_ff
);

   logic signed [MUL_A_W+MUL_B_W-1:0] full_prod;

   assign full_prod = mul_a * mul_b;

   // Operands never exceed 45 magnitude bits, so the upper bits are sign copies.
   always_ff @(posedge clock) begin
      prod_ff <= full_prod[PROD_W-1:0];
   end

endmodule

// ===== hdl/hexapod_gait_leg_trajectory.sv =====
// -----------------------------------------------------------------------------
// Hexapod gait leg trajectory generator
// Turns body velocity ticks into six per-leg stance offsets.
// -----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel is one gait tick carrying vel_x,
// vel_y and yaw_rate. A tick with all three zero is taken and dropped; any
// other tick produces six transfers on the rsp_ channel, legs 0 to 5 in
// order, with rsp_tlast on leg 5. The per-leg start stance lives in a small
// synchronous memory that is read once per leg and written back at the end
// of each phase.
// Timing: the block handles one tick at a time. A tick first forms the three
// velocity by period products, then runs each leg through read, three
// products, finish and output steps on the one shared multiplier. Each leg
// is presented when its output step hands it to the output register, and
// the next tick can be accepted once the last leg has been handed over.
// req_tready is high only while no tick is in progress. A stalled receiver
// holds the sequencer in its output step; the finished leg waits in the
// output register.
// Reset: gait type tripod, tick period 655, phase and step zero and every
// stored stance zero through per-entry valid bits, so no clearing pass is
// needed. A write of the gait type register clears phase, step and stance again.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hexapod_gait_leg_trajectory
   import hgl_pkg::*;
#(
   parameter int STEPS_PER_PHASE = STEPS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // vel_x [19:0], vel_y [39:20], yaw_rate [59:40]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // off_x, off_y, off_z, off_rot, 32 bits each
   output logic [2:0]    rsp_tuser,   // leg_index
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata
);

`include "hexapod_gait_leg_trajectory_assert.svh"

   localparam int SW = $clog2(STEPS_PER_PHASE + 1);
   localparam int MW = SW + 4;
   localparam int TICK_RESET = 655;
   localparam int LIFT_DEPTH = 2 ** SW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_VT0, ST_VT1, ST_VT2, ST_VTW,
      ST_LRD, ST_LM0, ST_LM1, ST_LM2, ST_LFIN, ST_EMIT
   } state_type;

   state_type state_ff;

   logic [1:0]               gait_ff;
   logic [15:0]              tick_ff;
   logic [3:0]               phase_ff;
   logic [SW-1:0]            step_ff;
   logic [LEG_W-1:0]         leg_ff;
   logic [NUM_LEGS-1:0]      valid_ff;
   logic                     rd_valid_ff;
   logic signed [VEL_W-1:0]  vel_ff [3];
   logic signed [MUL_A_W-1:0] vt_ff [3];
   logic [MW-1:0]            m_ff;
   role_type                 role_ff;
   logic signed [OFF_W-1:0]  res_ff [3];
   logic [95:0]              start_mem [NUM_LEGS];
   logic [95:0]              mem_q_ff;

   logic [LIFT_W-1:0]        lift_tab [LIFT_DEPTH];

   logic                     rsp_valid_ff;
   logic [127:0]             rsp_data_ff;
   logic [2:0]               rsp_leg_ff;
   logic                     rsp_last_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic                     end_phase;
   logic                     emit_go;
   logic                     mem_we;
   logic [3:0]               phase_in;
   role_type                 role_now;
   logic [SW-1:0]            step_p1;
   logic [SW-1:0]            step_rem;
   logic [1:0]               cons_sel;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] start_val;
   logic signed [PROD_W-1:0] comp_val;
   logic signed [OFF_W-1:0]  comp_res;
   logic [LIFT_W-1:0]        lift_z;

   // The lift table is padded to a power of two; entries past the last step are zero.
   genvar k;
   generate
      for (k = 0; k < LIFT_DEPTH; k++) begin : g_lift
         localparam int LV = (k < STEPS_PER_PHASE) ?
            (LIFT_Q16 * k + STEPS_PER_PHASE / 2) / STEPS_PER_PHASE : 0;
         assign lift_tab[k] = LIFT_W'(LV);
      end
   endgenerate

   hgl_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign end_phase = (step_ff == SW'(STEPS_PER_PHASE - 1));
   assign role_now  = leg_role(gait_ff, phase_ff, leg_ff);
   assign step_p1   = step_ff + SW'(1);
   assign step_rem  = SW'(STEPS_PER_PHASE) - step_ff;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign mem_we    = emit_go && end_phase;
   assign phase_in  = (phase_ff == gait_last_phase(gait_ff)) ? 4'd0 : phase_ff + 4'd1;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_VT0: begin
            mul_a = MUL_A_W'(vel_ff[0]);
            mul_b = MUL_B_W'(tick_ff);
         end
         ST_VT1: begin
            mul_a = MUL_A_W'(vel_ff[1]);
            mul_b = MUL_B_W'(tick_ff);
         end
         ST_VT2: begin
            mul_a = MUL_A_W'(vel_ff[2]);
            mul_b = MUL_B_W'(tick_ff);
         end
         ST_LM0: begin
            mul_a = vt_ff[0];
            mul_b = MUL_B_W'(m_ff);
         end
         ST_LM1: begin
            mul_a = vt_ff[1];
            mul_b = MUL_B_W'(m_ff);
         end
         ST_LM2: begin
            mul_a = vt_ff[2];
            mul_b = MUL_B_W'(m_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Finish one offset component from the product of the previous cycle.
   // Every role is rounded at bit 17; returning legs use a doubled factor.
   always_comb begin
      case (state_ff)
         ST_LM2:  cons_sel = 2'd1;
         ST_LFIN: cons_sel = 2'd2;
         default: cons_sel = 2'd0;
      endcase
      rnd = (prod + PROD_W'(65536)) >>> 17;
      start_val = '0;
      if (rd_valid_ff) begin
         case (cons_sel)
            2'd1:    start_val = PROD_W'($signed(mem_q_ff[63:32]));
            2'd2:    start_val = PROD_W'($signed(mem_q_ff[95:64]));
            default: start_val = PROD_W'($signed(mem_q_ff[31:0]));
         endcase
      end
      case (role_ff)
         ROLE_UP:   comp_val = -rnd;
         ROLE_DOWN: comp_val = rnd;
         default:   comp_val = start_val - rnd;
      endcase
      comp_res = sat32(comp_val);
      case (role_ff)
         ROLE_UP:   lift_z = lift_tab[step_ff];
         ROLE_DOWN: lift_z = lift_tab[SW'(STEPS_PER_PHASE - 1) - step_ff];
         default:   lift_z = '0;
      endcase
   end

   // Start stance memory: one entry per leg holding x, y and rotation.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[leg_ff] <= {res_ff[2], res_ff[1], res_ff[0]};
      end
      mem_q_ff <= start_mem[leg_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         vel_ff[0] <= req_tdata[19:0];
         vel_ff[1] <= req_tdata[39:20];
         vel_ff[2] <= req_tdata[59:40];
      end
      case (state_ff)
         ST_VT1: vt_ff[0] <= prod[MUL_A_W-1:0];
         ST_VT2: vt_ff[1] <= prod[MUL_A_W-1:0];
         ST_VTW: vt_ff[2] <= prod[MUL_A_W-1:0];
         ST_LM1: res_ff[0] <= comp_res;
         ST_LM2: res_ff[1] <= comp_res;
         ST_LFIN: res_ff[2] <= comp_res;
         default: ;
      endcase
      if (state_ff == ST_LRD) begin
         role_ff <= role_now;
         case (role_now)
            ROLE_UP:   m_ff <= MW'(step_rem) * MW'(gait_c(gait_ff));
            ROLE_DOWN: m_ff <= MW'(step_p1) * MW'(gait_c(gait_ff));
            default:   m_ff <= MW'({step_p1, 1'b0});
         endcase
         rd_valid_ff <= valid_ff[leg_ff];
      end
      if (emit_go) begin
         rsp_data_ff <= {res_ff[2], OFF_W'(lift_z), res_ff[1], res_ff[0]};
         rsp_leg_ff  <= leg_ff;
         rsp_last_ff <= (leg_ff == LEG_W'(NUM_LEGS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gait_ff      <= GAIT_TRIPOD;
         tick_ff      <= 16'(TICK_RESET);
         phase_ff     <= '0;
         step_ff      <= '0;
         leg_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new leg enters the output register as the old one leaves it.
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (csr_index == 1'b0) begin
               gait_ff  <= csr_wdata[1:0];
               phase_ff <= '0;
               step_ff  <= '0;
               valid_ff <= '0;
            end else begin
               tick_ff <= csr_wdata;
            end
         end
         case (state_ff)
            ST_IDLE: begin
               leg_ff <= '0;
               if (req_tvalid && req_tdata[59:0] != 60'd0) begin
                  state_ff <= ST_VT0;
               end
            end
            ST_VT0:  state_ff <= ST_VT1;
            ST_VT1:  state_ff <= ST_VT2;
            ST_VT2:  state_ff <= ST_VTW;
            ST_VTW:  state_ff <= ST_LRD;
            ST_LRD:  state_ff <= ST_LM0;
            ST_LM0:  state_ff <= ST_LM1;
            ST_LM1:  state_ff <= ST_LM2;
            ST_LM2:  state_ff <= ST_LFIN;
            ST_LFIN: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (emit_go) begin
                  if (end_phase) begin
                     valid_ff[leg_ff] <= 1'b1;
                  end
                  if (leg_ff == LEG_W'(NUM_LEGS - 1)) begin
                     state_ff <= ST_IDLE;
                     if (end_phase) begin
                        step_ff  <= '0;
                        phase_ff <= phase_in;
                     end else begin
                        step_ff <= step_p1;
                     end
                  end else begin
                     leg_ff   <= leg_ff + LEG_W'(1);
                     state_ff <= ST_LRD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_leg_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HGL_ASSERT(a_leg_range, leg_ff <= LEG_W'(NUM_LEGS - 1), "leg counter out of range")
   `HGL_ASSERT_IMP(a_wb_end, mem_we, step_ff == SW'(STEPS_PER_PHASE - 1),
      "stance written back before the end of a phase")
   `HGL_ASSERT_IMP(a_last_leg, rsp_tvalid && rsp_tlast, rsp_tuser == LEG_W'(NUM_LEGS - 1),
      "last marker on a leg other than the sixth")
   `HGL_ASSERT_IMP(a_step_range, state_ff != ST_IDLE,
      step_ff < SW'(STEPS_PER_PHASE), "phase step out of range")

endmodule

// ===== test/tb_top.sv =====
// -----------------------------------------------------------------------------
// Hexapod gait leg trajectory testbench
// Drives velocity ticks under random backpressure, predicts the six leg
// offsets per tick in the testbench and compares every response transfer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import hgl_pkg::*;

   localparam int STEPS = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic CSR_GAIT = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   typedef struct packed {
      logic [2:0]         leg;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] rot;
      logic               last;
   } leg_offset_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;   // vel_x [19:0], vel_y [39:20], yaw_rate [59:40]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;   // off_x, off_y, off_z, off_rot from bit 0 up
   logic [2:0]    rsp_tuser;   // leg_index
   logic          rsp_tlast;
   logic          csr_we;
   logic          csr_index;
   logic [15:0]   csr_wdata;

   // Predictor state mirrors the block's phase counters and stored stance.
   logic [1:0]          gait_sel;
   logic [15:0]         period;
   int unsigned         phase_idx;
   int unsigned         step_idx;
   logic signed [31:0]  stance_x[6];
   logic signed [31:0]  stance_y[6];
   logic signed [31:0]  stance_rot[6];

   leg_offset_type expected_offsets[$];
   int          error_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   hexapod_gait_leg_trajectory i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint round_div(input longint n, input int sh);
      return (n + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // The tables are written out here independently of the package.
   function automatic role_type role_of(input int unsigned ph, input int leg);
      case (gait_sel)
         GAIT_RIPPLE: begin
            case (ph)
               0: return leg == 1 ? ROLE_DOWN : leg == 5 ? ROLE_UP : ROLE_RET;
               1: return leg == 0 ? ROLE_UP : leg == 5 ? ROLE_DOWN : ROLE_RET;
               2: return leg == 0 ? ROLE_DOWN : leg == 4 ? ROLE_UP : ROLE_RET;
               3: return leg == 2 ? ROLE_UP : leg == 4 ? ROLE_DOWN : ROLE_RET;
               4: return leg == 2 ? ROLE_DOWN : leg == 3 ? ROLE_UP : ROLE_RET;
               default: return leg == 1 ? ROLE_UP : leg == 3 ? ROLE_DOWN : ROLE_RET;
            endcase
         end
         GAIT_WAVE: begin
            if (leg != ph / 2) return ROLE_RET;
            return ph % 2 ? ROLE_DOWN : ROLE_UP;
         end
         default: begin
            if ((leg % 2) != ((ph / 2) % 2)) return ROLE_RET;
            return ph % 2 ? ROLE_DOWN : ROLE_UP;
         end
      endcase
   endfunction

   function automatic void predict_tick(input logic signed [19:0] vx,
                                        input logic signed [19:0] vy,
                                        input logic signed [19:0] vr);
      longint vel[3];
      longint c;
      longint s;
      longint t;
      int unsigned phases;
      logic signed [31:0] st[3];
      leg_offset_type o;
      leg_offset_type row[6];
      if (vx == 0 && vy == 0 && vr == 0) return;
      phases = gait_sel == GAIT_RIPPLE ? 6 : gait_sel == GAIT_WAVE ? 12 : 4;
      vel[0] = vx;
      vel[1] = vy;
      vel[2] = vr;
      c = phases - 2;
      s = step_idx;
      t = longint'(period);
      for (int leg = 0; leg < 6; leg++) begin
         st[0] = stance_x[leg];
         st[1] = stance_y[leg];
         st[2] = stance_rot[leg];
         case (role_of(phase_idx, leg))
            ROLE_UP: begin
               for (int k = 0; k < 3; k++)
                  st[k] = clamp32(-round_div((STEPS - s) * vel[k] * t * c, 17));
               o.z = 32'((LIFT_Q16 * s + STEPS / 2) / STEPS);
            end
            ROLE_DOWN: begin
               for (int k = 0; k < 3; k++)
                  st[k] = clamp32(round_div((s + 1) * vel[k] * t * c, 17));
               o.z = 32'((LIFT_Q16 * (STEPS - 1 - s) + STEPS / 2) / STEPS);
            end
            default: begin
               for (int k = 0; k < 3; k++)
                  st[k] = clamp32(longint'(st[k]) - round_div((s + 1) * vel[k] * t, 16));
               o.z = 0;
            end
         endcase
         o.leg = 3'(leg);
         o.x = st[0];
         o.y = st[1];
         o.rot = st[2];
         o.last = (leg == 5);
         row[leg] = o;
         expected_offsets.insert(expected_offsets.size(), o);
      end
      if (step_idx + 1 >= STEPS) begin
         step_idx = 0;
         for (int leg = 0; leg < 6; leg++) begin
            stance_x[leg] = row[leg].x;
            stance_y[leg] = row[leg].y;
            stance_rot[leg] = row[leg].rot;
         end
         phase_idx = (phase_idx + 1) % phases;
      end else begin
         step_idx++;
      end
   endfunction

   // Response checker: every accepted leg transfer is compared with the oldest one.
   always @(posedge clock) begin
      leg_offset_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_offsets.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_tuser), 32'd0);
         end else begin
            want = expected_offsets.pop_front();
            if (rsp_tuser !== want.leg)
               report_mismatch("leg", 32'(rsp_tuser), 32'(want.leg));
            if (rsp_tdata[31:0] !== want.x) report_mismatch("off_x", rsp_tdata[31:0], want.x);
            if (rsp_tdata[63:32] !== want.y)
               report_mismatch("off_y", rsp_tdata[63:32], want.y);
            if (rsp_tdata[95:64] !== want.z)
               report_mismatch("off_z", rsp_tdata[95:64], want.z);
            if (rsp_tdata[127:96] !== want.rot)
               report_mismatch("off_rot", rsp_tdata[127:96], want.rot);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // Receiver backpressure follows the current idle percentage.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // One tick transfer; the predictor runs when it is accepted. The request
   // stays up after acceptance so that the next tick can follow directly.
   task automatic send_tick(input logic signed [19:0] vx, input logic signed [19:0] vy,
                            input logic signed [19:0] vr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, vr, vy, vx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(vx, vy, vr);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_offsets.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Register writes happen only when the block is idle.
   task automatic write_csr(input logic idx, input logic [15:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GAIT) begin
         gait_sel = value[1:0];
         phase_idx = 0;
         step_idx = 0;
         for (int leg = 0; leg < 6; leg++) begin
            stance_x[leg] = 0;
            stance_y[leg] = 0;
            stance_rot[leg] = 0;
         end
      end else begin
         period = value;
      end
   endtask

   function automatic logic [19:0] random_speed();
      case ($urandom_range(4))
         0: return 20'h7ffff;
         1: return 20'h80000;
         2: return 20'($urandom_range(511) - 256);
         default: return 20'($urandom());
      endcase
   endfunction

   // Extremes of every field, zero ticks mixed in, period zero and maximum.
   task automatic test_directed();
      send_tick(20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
      send_tick(20'sh80000, 20'sh80000, 20'sh80000);
      send_tick(0, 0, 0);
      send_tick(1, 0, 0);
      send_tick(0, -1, 0);
      send_tick(0, 0, 1);
      write_csr(CSR_PERIOD, 16'hffff);
      for (int i = 0; i < 10; i++) send_tick(20'sh7ffff, 20'sh80000, 20'sh7ffff);
      write_csr(CSR_PERIOD, 16'd0);
      send_tick(20'sh12345, 20'sh54321, 20'sh0abcd);
      send_tick(20'sh80000, 0, 0);
      write_csr(CSR_PERIOD, 16'd1);
      send_tick(20'sh0aaaa, 20'sh55555, 20'shfffff);
   endtask

   // Random ticks in one gait; the gait is written again even if unchanged.
   task automatic test_gait(input logic [1:0] gait, input int ticks);
      write_csr(CSR_GAIT, 16'(gait));
      write_csr(CSR_PERIOD,
                $urandom_range(3) == 0 ? 16'hffff : 16'($urandom_range(1, 2000)));
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(19) == 0) send_tick(0, 0, 0);
         else send_tick(random_speed(), random_speed(), random_speed());
      end
   endtask

   // The sender stops until every outstanding leg result has arrived.
   task automatic test_drain_pause();
      send_tick(20'sh00100, 20'sh00200, -20'sh00300);
      req_tvalid <= 1'b0;
      while (expected_offsets.size() != 0) @(posedge clock);
      send_tick(20'sh00400, 0, 20'sh00010);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      error_count = 0;
      cycle_count = 0;
      gait_sel = GAIT_TRIPOD;
      period = 16'd655;
      phase_idx = 0;
      step_idx = 0;
      for (int leg = 0; leg < 6; leg++) begin
         stance_x[leg] = 0;
         stance_y[leg] = 0;
         stance_rot[leg] = 0;
      end
      send_idle_pct = 18;
      recv_idle_pct = 67;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_gait(GAIT_TRIPOD, 40);
      test_drain_pause();
      send_idle_pct = 67;
      recv_idle_pct = 18;
      test_gait(GAIT_RIPPLE, 55);
      test_gait(GAIT_WAVE, 70);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_gait(2'd3, 35);
      test_gait(GAIT_TRIPOD, 10);

      wait_drained();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
